// ----- hdl/falling_particle_frame_step_macros.svh -----
// Assertion macros for the falling particle frame step RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef FALLING_PARTICLE_FRAME_STEP_MACROS_SVH
`define FALLING_PARTICLE_FRAME_STEP_MACROS_SVH

// Checked only while out of reset.
`define FPFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define FPFS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- hdl/fpfs_pkg.sv -----
// Package for the falling particle frame step: geometry, codes, FSM states,
// port structs and helper functions. No dependencies.
package fpfs_pkg;

    localparam int ROWS      = 120;
    // COLUMNS must be a power of two: the spawn column is the low draw bits.
    localparam int COLUMNS   = 32;
    localparam int GROUPS    = (ROWS + 7) / 8;
    localparam int PIX_BYTES = GROUPS * COLUMNS;

    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int PIX_AW   = $clog2(PIX_BYTES);
    localparam int SEED_W   = 8;
    localparam int KEY_W    = 8;
    localparam int ADDR_W   = 9;
    localparam int SPAWN_W  = 5;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam int LCG_MUL = 89;
    localparam int LCG_ADD = 79;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STEP  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SPAWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ  = 2'd3;

    localparam logic [1:0] STEP_LEFT  = 2'd0;
    localparam logic [1:0] STEP_RIGHT = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_ROW,
        S_COL,
        S_DIAG,
        S_STR,
        S_SET,
        S_SRC_RD,
        S_SRC_WR,
        S_NEXT,
        S_SPAWN,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SPAWN_W-1:0]  spawn_column;
        logic [BYTE_W-1:0]   read_byte;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [PIX_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [PIX_AW-1:0] raddr;
    } t_pix_port;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [COL_W-1:0] wdata;
        logic [ROW_W-1:0] raddr;
    } t_col_port;

    // x mod 3 for 8-bit x: quotient by reciprocal 171/512, then subtract.
    function automatic logic [1:0] mod3(input logic [7:0] x);
        logic [16:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 17'(x) * 17'(171);
        q = p[16:9];
        r = x - 8'(q * 8'd3);
        mod3 = r[1:0];
    endfunction

    function automatic logic [PIX_AW-1:0] pix_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [PIX_AW-1:0] g;
        g = PIX_AW'(row >> 3);
        pix_addr = PIX_AW'(g * PIX_AW'(COLUMNS)) + PIX_AW'(col);
    endfunction

    function automatic logic [BYTE_W-1:0] row_mask(input logic [ROW_W-1:0] row);
        row_mask = BYTE_W'(1) << row[2:0];
    endfunction

endpackage

// ----- hdl/falling_particle_frame_step.sv -----
// Falling particle frame step, top level: stream ports, output register, RAMs.
// Depends on fpfs_pkg, fpfs_ram, fpfs_lcg and fpfs_ctrl.

// After reset the block clears all 480 bytes of the bitmap RAM and takes no
// beat until that is done. A frame step visits each of the 119 rows, then
// runs the spawn search, one column per cycle; when the search reaches column
// 16 without a free top-row cell, the top row is taken as full and another
// clearing pass follows before the result. The bitmap RAM has a single read
// and a single write port. A finished result waits in the output register
// while the next beat is taken.
module falling_particle_frame_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key_count[7:0], byte_addr[16:8], zero fill
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // spawn_column[4:0], read_byte[12:5], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    fpfs_pkg::t_pix_port               pix;
    fpfs_pkg::t_col_port               col;
    fpfs_pkg::t_result                 res;
    logic [fpfs_pkg::BYTE_W-1:0]       pix_rdata;
    logic [fpfs_pkg::COL_W-1:0]        col_rdata;
    logic                              draw;
    logic [fpfs_pkg::SEED_W-1:0]       rand_val;
    logic [1:0]                        rand_mod3;
    logic                              res_valid;
    logic                              res_ready;

    logic                              r_m_valid;
    fpfs_pkg::t_result                 r_m_res;

    fpfs_ram #(
        .DEPTH (fpfs_pkg::PIX_BYTES),
        .WIDTH (fpfs_pkg::BYTE_W)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix.we),
        .i_waddr (pix.waddr),
        .i_wdata (pix.wdata),
        .i_raddr (pix.raddr),
        .o_rdata (pix_rdata)
    );

    fpfs_ram #(
        .DEPTH (fpfs_pkg::ROWS),
        .WIDTH (fpfs_pkg::COL_W)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col.we),
        .i_waddr (col.waddr),
        .i_wdata (col.wdata),
        .i_raddr (col.raddr),
        .o_rdata (col_rdata)
    );

    fpfs_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_draw  (draw),
        .o_rand  (rand_val),
        .o_mod3  (rand_mod3)
    );

    fpfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser[0]),
        .i_key_count (s_axis_tdata[7:0]),
        .i_byte_addr (s_axis_tdata[16:8]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_pix       (pix),
        .i_pix_rdata (pix_rdata),
        .o_col       (col),
        .i_col_rdata (col_rdata),
        .o_draw      (draw),
        .i_rand      (rand_val),
        .i_rand_mod3 (rand_mod3)
    );

    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {3'b000, r_m_res.read_byte, r_m_res.spawn_column};

endmodule

// ----- hdl/fpfs_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module fpfs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fpfs_lcg.sv -----
// 8-bit linear congruential generator with mod-3 of the drawn value.
// Depends on fpfs_pkg.
module fpfs_lcg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_draw,
    output logic [fpfs_pkg::SEED_W-1:0] o_rand,
    output logic [1:0]                  o_mod3
);

    logic [fpfs_pkg::SEED_W-1:0]   r_seed;
    logic [fpfs_pkg::SEED_W-1:0]   n_seed;
    logic [2*fpfs_pkg::SEED_W-1:0] prod;

    always_comb begin
        prod   = (2*fpfs_pkg::SEED_W)'(r_seed) * (2*fpfs_pkg::SEED_W)'(fpfs_pkg::LCG_MUL);
        n_seed = prod[fpfs_pkg::SEED_W-1:0] + fpfs_pkg::SEED_W'(fpfs_pkg::LCG_ADD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_draw) begin
            r_seed <= n_seed;
        end
    end

    assign o_rand = n_seed;
    assign o_mod3 = fpfs_pkg::mod3(n_seed);

endmodule

// ----- hdl/fpfs_ctrl.sv -----
// Frame step sequencer: row walk, spawn search, clearing pass and byte read.
// Depends on fpfs_pkg and falling_particle_frame_step_macros.svh.
`include "falling_particle_frame_step_macros.svh"

module fpfs_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [fpfs_pkg::KEY_W-1:0]       i_key_count,
    input  logic [fpfs_pkg::ADDR_W-1:0]      i_byte_addr,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output fpfs_pkg::t_result                o_res,
    output fpfs_pkg::t_pix_port              o_pix,
    input  logic [fpfs_pkg::BYTE_W-1:0]      i_pix_rdata,
    output fpfs_pkg::t_col_port              o_col,
    input  logic [fpfs_pkg::COL_W-1:0]       i_col_rdata,
    output logic                             o_draw,
    input  logic [fpfs_pkg::SEED_W-1:0]      i_rand,
    input  logic [1:0]                       i_rand_mod3
);

    fpfs_pkg::t_state                 r_state, n_state;
    logic [fpfs_pkg::ROW_W-1:0]       r_row, n_row;
    logic [fpfs_pkg::COL_W-1:0]       r_col, n_col;
    logic [fpfs_pkg::COL_W-1:0]       r_dst, n_dst;
    logic [fpfs_pkg::BYTE_W-1:0]      r_byte, n_byte;
    logic [fpfs_pkg::PIX_AW-1:0]      r_addr, n_addr;
    logic                             r_full, n_full;
    logic [fpfs_pkg::KEY_W-1:0]       r_count, n_count;
    logic [fpfs_pkg::KEY_W-1:0]       r_key, n_key;
    fpfs_pkg::t_result                r_res, n_res;
    logic [fpfs_pkg::ROWS-1:0]        r_valid, n_valid;

    logic [fpfs_pkg::ROW_W-1:0]       row_dn;
    logic [fpfs_pkg::COL_W-1:0]       tcol;
    logic                             diag;

    assign row_dn = r_row + fpfs_pkg::ROW_W'(1);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_dst   = r_dst;
        n_byte  = r_byte;
        n_addr  = r_addr;
        n_full  = r_full;
        n_count = r_count;
        n_key   = r_key;
        n_res   = r_res;
        n_valid = r_valid;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_draw      = 1'b0;
        o_pix       = '0;
        o_col       = '0;
        tcol        = r_col;
        diag        = 1'b0;

        unique case (r_state)
            fpfs_pkg::S_CLEAR: begin
                o_pix.we    = 1'b1;
                o_pix.waddr = r_addr;
                if (r_addr == fpfs_pkg::PIX_AW'(fpfs_pkg::PIX_BYTES - 1)) begin
                    n_addr  = '0;
                    n_full  = 1'b0;
                    n_state = r_full ? fpfs_pkg::S_DONE : fpfs_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + fpfs_pkg::PIX_AW'(1);
                end
            end
            fpfs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == fpfs_pkg::CMD_READ) begin
                        n_res = '{status: fpfs_pkg::ST_READ, spawn_column: '0, read_byte: '0};
                        if (i_byte_addr < fpfs_pkg::ADDR_W'(fpfs_pkg::PIX_BYTES)) begin
                            o_pix.raddr = fpfs_pkg::PIX_AW'(i_byte_addr);
                            n_state     = fpfs_pkg::S_RD_WAIT;
                        end else begin
                            n_state = fpfs_pkg::S_DONE;
                        end
                    end else begin
                        n_key   = i_key_count;
                        n_row   = fpfs_pkg::ROW_W'(fpfs_pkg::ROWS - 2);
                        n_state = fpfs_pkg::S_ROW;
                    end
                end
            end
            fpfs_pkg::S_RD_WAIT: begin
                n_res.read_byte = i_pix_rdata;
                n_state         = fpfs_pkg::S_DONE;
            end
            fpfs_pkg::S_ROW: begin
                if (r_valid[r_row]) begin
                    n_valid[r_row] = 1'b0;
                    o_col.raddr    = r_row;
                    n_state        = fpfs_pkg::S_COL;
                end else if (r_row == '0) begin
                    n_state = fpfs_pkg::S_SPAWN;
                end else begin
                    n_row = r_row - fpfs_pkg::ROW_W'(1);
                end
            end
            fpfs_pkg::S_COL: begin
                o_draw = 1'b1;
                n_col  = i_col_rdata;
                tcol   = i_col_rdata;
                if (i_rand_mod3 == fpfs_pkg::STEP_LEFT && i_col_rdata != '0) begin
                    tcol = i_col_rdata - fpfs_pkg::COL_W'(1);
                    diag = 1'b1;
                end else if (i_rand_mod3 == fpfs_pkg::STEP_RIGHT &&
                             i_col_rdata != fpfs_pkg::COL_W'(fpfs_pkg::COLUMNS - 1)) begin
                    tcol = i_col_rdata + fpfs_pkg::COL_W'(1);
                    diag = 1'b1;
                end
                n_dst       = tcol;
                o_pix.raddr = fpfs_pkg::pix_addr(row_dn, tcol);
                n_state     = diag ? fpfs_pkg::S_DIAG : fpfs_pkg::S_STR;
            end
            fpfs_pkg::S_DIAG: begin
                if (!i_pix_rdata[row_dn[2:0]]) begin
                    n_byte  = i_pix_rdata;
                    n_state = fpfs_pkg::S_SET;
                end else begin
                    n_dst       = r_col;
                    o_pix.raddr = fpfs_pkg::pix_addr(row_dn, r_col);
                    n_state     = fpfs_pkg::S_STR;
                end
            end
            fpfs_pkg::S_STR: begin
                if (!i_pix_rdata[row_dn[2:0]]) begin
                    n_byte  = i_pix_rdata;
                    n_state = fpfs_pkg::S_SET;
                end else begin
                    n_state = fpfs_pkg::S_NEXT;
                end
            end
            fpfs_pkg::S_SET: begin
                o_pix.we        = 1'b1;
                o_pix.waddr     = fpfs_pkg::pix_addr(row_dn, r_dst);
                o_pix.wdata     = r_byte | fpfs_pkg::row_mask(row_dn);
                o_col.we        = 1'b1;
                o_col.waddr     = row_dn;
                o_col.wdata     = r_dst;
                n_valid[row_dn] = 1'b1;
                n_state         = fpfs_pkg::S_SRC_RD;
            end
            fpfs_pkg::S_SRC_RD: begin
                o_pix.raddr = fpfs_pkg::pix_addr(r_row, r_col);
                n_state     = fpfs_pkg::S_SRC_WR;
            end
            fpfs_pkg::S_SRC_WR: begin
                o_pix.we    = 1'b1;
                o_pix.waddr = fpfs_pkg::pix_addr(r_row, r_col);
                o_pix.wdata = i_pix_rdata & ~fpfs_pkg::row_mask(r_row);
                n_state     = fpfs_pkg::S_NEXT;
            end
            fpfs_pkg::S_NEXT: begin
                if (r_row == '0) begin
                    n_state = fpfs_pkg::S_SPAWN;
                end else begin
                    n_row   = r_row - fpfs_pkg::ROW_W'(1);
                    n_state = fpfs_pkg::S_ROW;
                end
            end
            fpfs_pkg::S_SPAWN: begin
                if (r_count != r_key) begin
                    n_count     = r_count + fpfs_pkg::KEY_W'(1);
                    o_draw      = 1'b1;
                    n_col       = i_rand[fpfs_pkg::COL_W-1:0];
                    o_pix.raddr = fpfs_pkg::pix_addr('0, i_rand[fpfs_pkg::COL_W-1:0]);
                    n_state     = fpfs_pkg::S_SEARCH;
                end else begin
                    n_res   = '{status: fpfs_pkg::ST_STEP, spawn_column: '0, read_byte: '0};
                    n_state = fpfs_pkg::S_DONE;
                end
            end
            fpfs_pkg::S_SEARCH: begin
                if (!i_pix_rdata[0]) begin
                    o_pix.we    = 1'b1;
                    o_pix.waddr = fpfs_pkg::pix_addr('0, r_col);
                    o_pix.wdata = i_pix_rdata | fpfs_pkg::BYTE_W'(1);
                    o_col.we    = 1'b1;
                    o_col.waddr = '0;
                    o_col.wdata = r_col;
                    n_valid[0]  = 1'b1;
                    n_res       = '{status: fpfs_pkg::ST_SPAWN,
                                    spawn_column: fpfs_pkg::SPAWN_W'(r_col),
                                    read_byte: '0};
                    n_state     = fpfs_pkg::S_DONE;
                end else if (r_col == fpfs_pkg::COL_W'(fpfs_pkg::COLUMNS / 2)) begin
                    n_valid = '0;
                    n_full  = 1'b1;
                    n_addr  = '0;
                    n_res   = '{status: fpfs_pkg::ST_FULL, spawn_column: '0, read_byte: '0};
                    n_state = fpfs_pkg::S_CLEAR;
                end else begin
                    tcol        = (r_col == '0) ? fpfs_pkg::COL_W'(fpfs_pkg::COLUMNS - 1)
                                                : r_col - fpfs_pkg::COL_W'(1);
                    n_col       = tcol;
                    o_pix.raddr = fpfs_pkg::pix_addr('0, tcol);
                end
            end
            fpfs_pkg::S_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = fpfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpfs_pkg::S_CLEAR;
            r_addr  <= '0;
            r_full  <= 1'b0;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_full  <= n_full;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_dst  <= n_dst;
        r_byte <= n_byte;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_res = r_res;

    `FPFS_ASSERT_RST(a_rst_clear, !i_rst_n |=> r_state == fpfs_pkg::S_CLEAR && r_addr == '0, "reset does not start clearing pass")
    `FPFS_ASSERT(a_res_once, o_res_valid |=> !o_res_valid, "result beat repeated")
    `FPFS_ASSERT(a_move_marks, $past(r_state == fpfs_pkg::S_SET) |-> r_valid[row_dn], "moved particle not marked active")
    `FPFS_ASSERT(a_spawn_active, o_res_valid && r_res.status == fpfs_pkg::ST_SPAWN |-> r_valid[0], "spawned particle not active in top row")

endmodule
